// ===== hw/rtl/brfs_pkg.sv =====
// Package for the byte ring FIFO with search.
// Holds payload structs, command and status codes, FSM states and cell control type.
// No dependencies.
package brfs_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int LEN_W         = 8;
    localparam int CFG_W         = 7;

    localparam logic [3:0] CMD_PUSH        = 4'd0;
    localparam logic [3:0] CMD_POP         = 4'd1;
    localparam logic [3:0] CMD_PEEK        = 4'd2;
    localparam logic [3:0] CMD_SEARCH      = 4'd3;
    localparam logic [3:0] CMD_SEARCH_CRLF = 4'd4;
    localparam logic [3:0] CMD_DROP_ONE    = 4'd5;
    localparam logic [3:0] CMD_ADVANCE     = 4'd6;
    localparam logic [3:0] CMD_DROP_CR     = 4'd7;
    localparam logic [3:0] CMD_DROP_CRLF   = 4'd8;
    localparam logic [3:0] CMD_EMPTY       = 4'd9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTYBUF  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] NOT_FOUND = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] data_byte;
        logic [7:0] position;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_byte;
        logic [7:0] found_position;
        logic [5:0] fill_count;
        logic [5:0] free_count;
    } out_item_t;

    typedef struct packed {
        logic       shift;
        logic       write;
        logic [7:0] wr_byte;
        logic [7:0] key;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/brfs_cell.sv =====
// One byte cell of the FIFO chain: holds the byte at one relative position.
// Takes the written byte when selected, else loads from its upper neighbor on a shift; flags key and LF matches.
// Depends on brfs_pkg.
module brfs_cell (
    input  logic                aclk,
    input  brfs_pkg::cell_ctrl_t ctrl,
    input  logic                wr_sel,
    input  logic [7:0]          nb_byte,
    output logic [7:0]          byte_out,
    output logic                key_hit,
    output logic                lf_hit
);
    import brfs_pkg::*;

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.write && wr_sel) begin
            byte_reg <= ctrl.wr_byte;
        end else if (ctrl.shift) begin
            byte_reg <= nb_byte;
        end
    end

    assign byte_out = byte_reg;
    assign key_hit  = (byte_reg == ctrl.key);
    assign lf_hit   = (byte_reg == CH_LF);

endmodule

// ===== hw/rtl/byte_ring_fifo_with_search.sv =====
// Byte ring FIFO with peek and search, built as a chain of byte cells (head at cell 0).
// Push, pop, peek, drop one and empty go straight from idle to the result state; searches scan
// the positions in turn (up to fill), advances and drops shift out one byte at a time.
// One command at a time: a new command is taken only once the last result is issued.
// Reset (aresetn, synchronous): buffer empty, buffer_length = min(64, MAX_SLOTS).
module byte_ring_fifo_with_search #(
    parameter int MAX_SLOTS = brfs_pkg::MAX_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  brfs_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output brfs_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import brfs_pkg::*;

    localparam int IW = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_SLOTS);
    localparam logic [LEN_W-1:0] LEN_RST = (MAX_SLOTS < 64) ? MAX_L : LEN_W'(64);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IW-1:0]     fill_reg, fill_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     lim_reg, lim_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [1:0]        sts_reg, sts_next;
    logic [7:0]        rb_reg, rb_next;
    logic [7:0]        fp_reg, fp_next;
    logic              mv_reg, mv_next;
    out_item_t         md_reg, md_next;

    cell_ctrl_t        ctrl;
    logic [7:0]        key_reg, key_next;
    logic [7:0]        cell_byte [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] key_vec, lf_vec;

    logic              s_xfer, cfg_xfer, empty, full, lf_ok;
    logic [8:0]        pos9, fill9;
    logic [IW-1:0]     pos_min, idx_p1;
    logic [LEN_W-1:0]  cfg_len;

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++) begin : g_cell
            brfs_cell u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .wr_sel  (fill_reg == IW'(g)),
                .nb_byte ((g == MAX_SLOTS - 1) ? cell_byte[g] : cell_byte[(g + 1) % MAX_SLOTS]),
                .byte_out(cell_byte[g]),
                .key_hit (key_vec[g]),
                .lf_hit  (lf_vec[g])
            );
        end
    endgenerate

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign m_valid   = mv_reg;
    assign m_data    = md_reg;

    assign empty   = (fill_reg == '0);
    assign full    = ((LEN_W'(fill_reg) + LEN_W'(1)) == len_reg);
    assign pos9    = {1'b0, s_data.position};
    assign fill9   = 9'(fill_reg);
    assign pos_min = (pos9 < fill9) ? IW'(s_data.position) : fill_reg;
    assign idx_p1  = idx_reg + IW'(1);
    assign lf_ok   = ((9'(idx_reg) + 9'd1) < fill9) && lf_vec[idx_p1];
    assign cfg_len = (cfg_data < 7'd2) ? LEN_W'(2) :
                     ((LEN_W'(cfg_data) > MAX_L) ? MAX_L : LEN_W'(cfg_data));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_RST;
            fill_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        lim_reg <= lim_next;
        cnt_reg <= cnt_next;
        cmd_reg <= cmd_next;
        sts_reg <= sts_next;
        rb_reg  <= rb_next;
        fp_reg  <= fp_next;
        key_reg <= key_next;
        md_reg  <= md_next;
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        sts_next     = sts_reg;
        rb_next      = rb_reg;
        fp_next      = fp_reg;
        key_next     = key_reg;
        mv_next      = mv_reg && !m_ready;
        md_next      = md_reg;
        ctrl.shift   = 1'b0;
        ctrl.write   = 1'b0;
        ctrl.wr_byte = s_data.data_byte;
        ctrl.key     = key_reg;

        case (state_reg)
            S_IDLE: begin
                if (cfg_xfer) begin
                    len_next  = cfg_len;
                    fill_next = '0;
                end else if (s_xfer) begin
                    cmd_next   = s_data.command;
                    sts_next   = ST_OK;
                    rb_next    = 8'd0;
                    fp_next    = NOT_FOUND;
                    idx_next   = '0;
                    key_next   = CH_CR;
                    lim_next   = fill_reg;
                    state_next = S_FIN;
                    case (s_data.command)
                        CMD_PUSH: begin
                            if (full) begin
                                sts_next = ST_FULL;
                            end else begin
                                ctrl.write = 1'b1;
                                fill_next  = fill_reg + IW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else begin
                                rb_next    = cell_byte[0];
                                ctrl.shift = 1'b1;
                                fill_next  = fill_reg - IW'(1);
                            end
                        end
                        CMD_PEEK: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else if (!(pos9 < fill9)) begin
                                sts_next = ST_NOT_FOUND;
                            end else begin
                                rb_next = cell_byte[IW'(s_data.position)];
                            end
                        end
                        CMD_SEARCH: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else begin
                                key_next   = s_data.data_byte;
                                lim_next   = pos_min;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SEARCH_CRLF, CMD_DROP_CR, CMD_DROP_CRLF: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DROP_ONE: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else begin
                                ctrl.shift = 1'b1;
                                fill_next  = fill_reg - IW'(1);
                            end
                        end
                        CMD_ADVANCE: begin
                            if (empty) begin
                                sts_next = ST_EMPTYBUF;
                            end else if (pos_min != '0) begin
                                cnt_next   = pos_min;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_EMPTY: begin
                            fill_next = '0;
                        end
                        default: begin
                            sts_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg == lim_reg) begin
                    sts_next   = ST_NOT_FOUND;
                    state_next = S_FIN;
                end else if (key_vec[idx_reg]) begin
                    state_next = S_FIN;
                    case (cmd_reg)
                        CMD_SEARCH: begin
                            fp_next = 8'(idx_reg);
                        end
                        CMD_DROP_CR: begin
                            fp_next    = 8'(idx_reg);
                            cnt_next   = idx_p1;
                            state_next = S_SHIFT;
                        end
                        CMD_SEARCH_CRLF, CMD_DROP_CRLF: begin
                            if (lf_ok) begin
                                fp_next = 8'(idx_reg);
                                if (cmd_reg == CMD_DROP_CRLF) begin
                                    cnt_next   = idx_reg + IW'(2);
                                    state_next = S_SHIFT;
                                end
                            end else begin
                                sts_next = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            sts_next = ST_NOT_FOUND;
                        end
                    endcase
                end else begin
                    idx_next = idx_p1;
                end
            end
            S_SHIFT: begin
                // one byte leaves the head per cycle
                ctrl.shift = 1'b1;
                fill_next  = fill_reg - IW'(1);
                cnt_next   = cnt_reg - IW'(1);
                if (cnt_reg == IW'(1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!mv_reg || m_ready) begin
                    mv_next               = 1'b1;
                    md_next.status        = sts_reg;
                    md_next.read_byte     = rb_reg;
                    md_next.found_position = fp_reg;
                    md_next.fill_count    = 6'(fill_reg);
                    md_next.free_count    = 6'(len_reg - LEN_W'(1) - LEN_W'(fill_reg));
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (LEN_W'(fill_reg) < len_reg))
        else $error("fill count reached buffer length");

    a_shift_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (cnt_reg != '0) && (fill_reg != '0))
        else $error("shift with nothing left to drop");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= lim_reg) && (lim_reg <= fill_reg))
        else $error("scan index past its limit");

endmodule

// ===== bench/byte_ring_fifo_with_search_checker.sv =====
// Checker for the byte ring FIFO with search: watches the command, result and
// register channels, keeps a predicted copy of the ring and compares each result.
// Depends on brfs_pkg.
`timescale 1ns / 100ps

module byte_ring_fifo_with_search_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  brfs_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  brfs_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [6:0]          cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  result_count
);
    import brfs_pkg::*;

    logic [7:0] ring [MAX_SLOTS_DEF];
    int unsigned wr_ptr, rd_ptr, slots;
    out_item_t expected_results [$];

    function automatic int unsigned held();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : slots + wr_ptr - rd_ptr;
    endfunction

    function automatic logic [7:0] byte_at(int unsigned p);
        int unsigned a;
        a = rd_ptr + p;
        if (a >= slots) a -= slots;
        return ring[a];
    endfunction

    function automatic int unsigned find_byte(logic [7:0] c, int unsigned lim);
        for (int unsigned i = 0; i < lim; i++)
            if (byte_at(i) == c) return i;
        return NOT_FOUND;
    endfunction

    // only the first CR counts
    function automatic int unsigned find_crlf();
        int unsigned f, p;
        f = held();
        p = find_byte(CH_CR, f);
        if (p != NOT_FOUND && p + 1 < f && byte_at(p + 1) == CH_LF) return p;
        return NOT_FOUND;
    endfunction

    function automatic void skip(int unsigned n);
        if (n > held()) n = held();
        rd_ptr = (rd_ptr + n) % slots;
    endfunction

    function automatic out_item_t apply_command(in_item_t c);
        out_item_t r;
        int unsigned f, fp, lim;
        f = held();
        r.status = ST_OK;
        r.read_byte = 8'd0;
        fp = NOT_FOUND;
        case (c.command)
            CMD_PUSH: begin
                if ((wr_ptr + 1) % slots == rd_ptr) r.status = ST_FULL;
                else begin
                    ring[wr_ptr] = c.data_byte;
                    wr_ptr = (wr_ptr + 1) % slots;
                end
            end
            CMD_POP: begin
                if (f == 0) r.status = ST_EMPTYBUF;
                else begin
                    r.read_byte = byte_at(0);
                    skip(1);
                end
            end
            CMD_PEEK: begin
                if (f == 0) r.status = ST_EMPTYBUF;
                else if (c.position >= f) r.status = ST_NOT_FOUND;
                else r.read_byte = byte_at(c.position);
            end
            CMD_SEARCH, CMD_SEARCH_CRLF: begin
                if (f == 0) r.status = ST_EMPTYBUF;
                else begin
                    lim = (c.position < f) ? c.position : f;
                    fp = (c.command == CMD_SEARCH) ? find_byte(c.data_byte, lim)
                                                   : find_crlf();
                    if (fp == NOT_FOUND) r.status = ST_NOT_FOUND;
                end
            end
            CMD_DROP_ONE, CMD_ADVANCE: begin
                if (f == 0) r.status = ST_EMPTYBUF;
                else skip(c.command == CMD_DROP_ONE ? 1 : c.position);
            end
            CMD_DROP_CR, CMD_DROP_CRLF: begin
                if (f == 0) r.status = ST_EMPTYBUF;
                else begin
                    fp = (c.command == CMD_DROP_CR) ? find_byte(CH_CR, f) : find_crlf();
                    if (fp == NOT_FOUND) r.status = ST_NOT_FOUND;
                    else skip(fp + (c.command == CMD_DROP_CR ? 1 : 2));
                end
            end
            CMD_EMPTY: rd_ptr = wr_ptr;
            default: r.status = ST_NOT_FOUND;
        endcase
        f = held();
        r.found_position = fp[7:0];
        r.fill_count = f[5:0];
        r.free_count = 6'(slots - 1 - f);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            wr_ptr = 0;
            rd_ptr = 0;
            slots = 64;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                // written length is clamped to 2..MAX_SLOTS
                if (cfg_data < 2) slots = 2;
                else if (cfg_data > MAX_SLOTS_DEF) slots = MAX_SLOTS_DEF;
                else slots = cfg_data;
                wr_ptr = 0;
                rd_ptr = 0;
            end
            if (s_valid && s_ready) expected_results.push_back(apply_command(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.read_byte !== want.read_byte)
                        report_mismatch("read_byte", m_data.read_byte, want.read_byte);
                    if (m_data.found_position !== want.found_position)
                        report_mismatch("found_position", m_data.found_position,
                                        want.found_position);
                    if (m_data.fill_count !== want.fill_count)
                        report_mismatch("fill_count", m_data.fill_count, want.fill_count);
                    if (m_data.free_count !== want.free_count)
                        report_mismatch("free_count", m_data.free_count, want.free_count);
                end
                result_count++;
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== bench/byte_ring_fifo_with_search_test.sv =====
// Top of the byte ring FIFO with search bench: clock, reset, command and register
// stimulus with random idling, and the verdict. Depends on brfs_pkg, the block
// and byte_ring_fifo_with_search_checker.
`timescale 1ns / 100ps

module byte_ring_fifo_with_search_test;
    import brfs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_item_t s_data;
    out_item_t m_data;
    logic [6:0] cfg_data;
    int fail_count, pending, result_count;
    int send_idle_pct, recv_idle_pct;
    int sent, idle_cycles;
    logic [6:0] cur_len;

    byte_ring_fifo_with_search dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_valid, .cfg_ready, .cfg_data
    );

    byte_ring_fifo_with_search_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_valid, .cfg_ready, .cfg_data,
        .fail_count, .pending, .result_count
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // receiver stalls at random
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // no-transfer watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL byte_ring_fifo_with_search");
            $finish;
        end
    end

    // valid stays up across back-to-back transfers; drain() drops it
    task automatic send_command(logic [3:0] cmd, logic [7:0] b, logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{command: cmd, data_byte: b, position: p};
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_length(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = (v < 2) ? 2 : v;
    endtask

    // random byte, biased toward CR and LF so the line commands find something
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return CH_CR;
            1: return CH_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [3:0] cmd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: cmd = CMD_PUSH;
                7, 8: cmd = CMD_POP;
                9, 10: cmd = CMD_PEEK;
                11, 12: cmd = CMD_SEARCH;
                13: cmd = CMD_SEARCH_CRLF;
                14: cmd = CMD_DROP_ONE;
                15: cmd = CMD_ADVANCE;
                16: cmd = CMD_DROP_CR;
                17: cmd = CMD_DROP_CRLF;
                18: cmd = ($urandom_range(3) == 0) ? CMD_EMPTY : CMD_PUSH;
                default: cmd = 4'($urandom_range(15));
            endcase
            send_command(cmd, pick_byte(),
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(cur_len)));
        end
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        sent = 0;
        idle_cycles = 0;
        cur_len = 64;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, undefined command, line endings, full buffer
        write_length(7'd0);
        send_command(CMD_POP, 8'h00, 8'h00);
        send_command(CMD_PEEK, 8'h00, 8'h00);
        send_command(CMD_SEARCH, 8'hFF, 8'hFF);
        send_command(CMD_SEARCH_CRLF, 8'h00, 8'h00);
        send_command(CMD_DROP_ONE, 8'h00, 8'h00);
        send_command(CMD_ADVANCE, 8'h00, 8'hFF);
        send_command(CMD_DROP_CR, 8'h00, 8'h00);
        send_command(CMD_DROP_CRLF, 8'h00, 8'h00);
        send_command(4'd15, 8'hFF, 8'hFF);
        send_command(CMD_PUSH, CH_CR, 8'h00);
        send_command(CMD_PUSH, 8'hFF, 8'h00);
        send_command(CMD_SEARCH_CRLF, 8'h00, 8'h00);
        send_command(CMD_DROP_CRLF, 8'h00, 8'h00);
        send_command(CMD_PEEK, 8'h00, 8'hFF);
        send_command(CMD_DROP_CR, 8'h00, 8'h00);
        write_length(7'd5);
        send_command(CMD_PUSH, 8'h55, 8'h00);
        send_command(CMD_PUSH, CH_CR, 8'h00);
        send_command(CMD_PUSH, CH_LF, 8'h00);
        send_command(CMD_PUSH, 8'hAA, 8'h00);
        send_command(CMD_PUSH, 8'h00, 8'h00);
        send_command(CMD_SEARCH, CH_LF, 8'h02);
        send_command(CMD_PEEK, 8'h00, 8'h03);
        send_command(CMD_DROP_CRLF, 8'h00, 8'h00);
        send_command(CMD_EMPTY, 8'h00, 8'h00);

        send_idle_pct = 29;
        recv_idle_pct = 81;
        write_length(7'd127);
        random_phase(140);
        // hold the sender until every result is back
        drain();
        random_phase(40);
        write_length(7'd1);
        random_phase(60);
        send_idle_pct = 81;
        recv_idle_pct = 29;
        write_length(7'd2);
        random_phase(60);
        write_length(7'($urandom_range(3, 63)));
        random_phase(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_length(7'd64);
        random_phase(80);
        write_length(7'd9);
        random_phase(50);
        drain();

        $display("covered %0d commands, %0d results, lengths 0..127 incl. clamped extremes",
                 sent, result_count);
        if (fail_count == 0) $display("PASS byte_ring_fifo_with_search");
        else $display("FAIL byte_ring_fifo_with_search");
        $finish;
    end

endmodule
